// ----- hdl/pbo_pkg.sv -----
// Shared constants for the band-limited oscillator: default sizes, waveform
// codes, fixed-point scale, sine polynomial coefficients and multiplier widths.
// No dependencies.
package pbo_pkg;

	// Default sizes
	localparam int DEF_PHASE_BITS     = 32;
	localparam int DEF_SINE_ADDR_BITS = 10;
	localparam int DEF_OUT_BITS       = 16;

	// Internal fixed-point fraction bits
	localparam int FRAC_BITS = 30;

	// Waveform codes
	localparam logic [1:0] WAVE_SINE     = 2'd0;
	localparam logic [1:0] WAVE_SAW      = 2'd1;
	localparam logic [1:0] WAVE_SQUARE   = 2'd2;
	localparam logic [1:0] WAVE_TRIANGLE = 2'd3;

	// Shared multiplier operand widths (signed)
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 35;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Odd sine coefficients, Q30, highest order first
	localparam logic [31:0] SIN_C11 = 32'd3864;
	localparam logic [31:0] SIN_C9  = 32'd172272;
	localparam logic [31:0] SIN_C7  = 32'd5026995;
	localparam logic [31:0] SIN_C5  = 32'd85569306;
	localparam logic [31:0] SIN_C3  = 32'd693598668;
	localparam logic [31:0] SIN_C1  = 32'd1686629713;

	// Horner coefficient for step 0..4 after the C11 seed
	function automatic logic [31:0] horner_coef(input logic [2:0] idx);
		logic [31:0] c;
		case (idx)
			3'd0:    c = SIN_C9;
			3'd1:    c = SIN_C7;
			3'd2:    c = SIN_C5;
			3'd3:    c = SIN_C3;
			3'd4:    c = SIN_C1;
			default: c = SIN_C1;
		endcase
		return c;
	endfunction

endpackage

// ----- hdl/pbo_div.sv -----
// Restoring fraction divider, one quotient bit per cycle.
// Gives floor(num * 2^30 / den) for num < den. Uses pbo_pkg.
module pbo_div #(
	parameter int PHASE_BITS = pbo_pkg::DEF_PHASE_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 go,
	input  logic [PHASE_BITS:0]                  num,
	input  logic [PHASE_BITS:0]                  den,
	output logic                                 done,
	output logic [pbo_pkg::FRAC_BITS-1:0]        quot
);

	localparam int QW = pbo_pkg::FRAC_BITS;
	localparam int CW = $clog2(QW + 1);

	logic [PHASE_BITS+1:0] rem_q;
	logic [PHASE_BITS:0]   den_q;
	logic [QW-1:0]         quot_q;
	logic [CW-1:0]         cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [PHASE_BITS+1:0] rem_sh;
	logic                  fits;

	// Shift the remainder and trial-subtract
	always_comb begin
		rem_sh = {rem_q[PHASE_BITS:0], 1'b0};
		fits   = rem_sh >= {1'b0, den_q};
	end

	// Control: iteration count and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !go && (cnt_q == CW'(QW - 1));
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(QW - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: remainder and quotient
	always_ff @(posedge clk) begin
		if (go) begin
			rem_q  <= {1'b0, num};
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? rem_sh - {1'b0, den_q} : rem_sh;
			quot_q <= {quot_q[QW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ----- hdl/pbo_mul.sv -----
// Shared signed multiplier, operands and product registered.
// Uses pbo_pkg for operand widths.
module pbo_mul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                go,
	input  logic signed [pbo_pkg::MUL_A_W-1:0]  a,
	input  logic signed [pbo_pkg::MUL_B_W-1:0]  b,
	output logic                                done,
	output logic signed [pbo_pkg::MUL_P_W-1:0]  prod
);

	logic                               go_s1;
	logic                               go_s2;
	logic signed [pbo_pkg::MUL_A_W-1:0] a_s1;
	logic signed [pbo_pkg::MUL_B_W-1:0] b_s1;
	logic signed [pbo_pkg::MUL_P_W-1:0] prod_s2;

	// Track the operation through the two stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_s1 <= 1'b0;
			go_s2 <= 1'b0;
		end else begin
			go_s1 <= go;
			go_s2 <= go_s1;
		end
	end

	// Register operands, then the product
	always_ff @(posedge clk) begin
		if (go) begin
			a_s1 <= a;
			b_s1 <= b;
		end
		prod_s2 <= a_s1 * b_s1;
	end

	assign done = go_s2;
	assign prod = prod_s2;

endmodule

// ----- hdl/polyblep_oscillator_core.sv -----
// Band-limited oscillator top level: sequencer and datapath around a shared
// multiplier (pbo_mul) and a bit-serial divider (pbo_div). Uses pbo_pkg.
//
// Usage
//   Input channel (in_valid / in_stall) carries phase_step and read_offset,
//   output channel (out_valid / out_stall) carries one sample per item.
//   An item is taken when valid is high and stall is low.
//   cfg_wen writes cfg_wdata into the waveform register (write when idle).
// Timing
//   One item at a time; in_stall is high from acceptance until the sample
//   is written to the output register, and the next item can be taken then.
//   Sine makes seven passes through the multiplier. Saw, square and
//   triangle add a divider run and a multiplier pass for each edge
//   correction that is needed (at most one for saw, two for square and
//   triangle), and triangle adds one multiplier pass for its integrator.
// Reset and back-pressure
//   Reset clears phase, triangle state, waveform (sine) and the output valid.
//   A finished sample waits in the output register while out_stall is
//   high; the next item is accepted meanwhile, and its result waits for
//   the output register to free.
module polyblep_oscillator_core #(
	parameter int PHASE_BITS     = pbo_pkg::DEF_PHASE_BITS,
	parameter int SINE_ADDR_BITS = pbo_pkg::DEF_SINE_ADDR_BITS,
	parameter int OUT_BITS       = pbo_pkg::DEF_OUT_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wen,
	input  logic [1:0]                 cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [PHASE_BITS-1:0]      phase_step,
	input  logic [PHASE_BITS-1:0]      read_offset,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [OUT_BITS-1:0] sample
);

	localparam int FB  = pbo_pkg::FRAC_BITS;
	localparam int VW  = 40;
	localparam int AW  = pbo_pkg::MUL_A_W;
	localparam int BW  = pbo_pkg::MUL_B_W;
	localparam int PW  = pbo_pkg::MUL_P_W;
	localparam int SHR = (PHASE_BITS >= FB) ? PHASE_BITS - FB : 0;
	localparam int SHL = (PHASE_BITS >= FB) ? 0 : FB - PHASE_BITS;
	localparam int RSH = FB - (OUT_BITS - 1);

	localparam logic signed [VW-1:0] ONE_V  = VW'(1) <<< FB;
	localparam logic signed [VW-1:0] RND_V  = VW'(1) <<< (RSH - 1);
	localparam logic signed [VW-1:0] OMAX_V = (VW'(1) <<< (OUT_BITS - 1)) - VW'(1);
	localparam logic signed [VW-1:0] OMIN_V = -(VW'(1) <<< (OUT_BITS - 1));
	localparam logic signed [VW-1:0] TMAX_V = (VW'(1) <<< 31) - VW'(1);
	localparam logic signed [VW-1:0] TMIN_V = -(VW'(1) <<< 31);

	localparam logic [PHASE_BITS-1:0] PH_HALF = PHASE_BITS'(1) << (PHASE_BITS - 1);
	localparam logic [PHASE_BITS:0]   PH_ONE  = (PHASE_BITS + 1)'(1) << PHASE_BITS;

	// Sequencer states
	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_START  = 4'd1;
	localparam logic [3:0] ST_SQW    = 4'd2;
	localparam logic [3:0] ST_HORN   = 4'd3;
	localparam logic [3:0] ST_HORNW  = 4'd4;
	localparam logic [3:0] ST_SINX   = 4'd5;
	localparam logic [3:0] ST_SINXW  = 4'd6;
	localparam logic [3:0] ST_BLEP   = 4'd7;
	localparam logic [3:0] ST_DIVW   = 4'd8;
	localparam logic [3:0] ST_RRW    = 4'd9;
	localparam logic [3:0] ST_TRI    = 4'd10;
	localparam logic [3:0] ST_TRIW   = 4'd11;
	localparam logic [3:0] ST_ROUND  = 4'd12;

	logic [3:0]               state_q;
	logic [1:0]               wave_q;
	logic [PHASE_BITS-1:0]    accum_q;
	logic [PHASE_BITS-1:0]    t_q;
	logic [PHASE_BITS-1:0]    dt_q;
	logic [PHASE_BITS-1:0]    bt_q;
	logic                     bidx_q;
	logic                     bneg_q;
	logic signed [VW-1:0]     v_q;
	logic signed [31:0]       tri_q;
	logic [31:0]              x2_q;
	logic [31:0]              p_q;
	logic [2:0]               hcnt_q;
	logic                     out_valid_q;
	logic signed [OUT_BITS-1:0] sample_q;

	logic [PHASE_BITS-1:0]    dt_in;
	logic                     accept;
	logic [1:0]               quad;
	logic [SINE_ADDR_BITS-1:0] addr;
	logic [SINE_ADDR_BITS:0]  kk;
	logic [31:0]              xval;
	logic signed [VW-1:0]     t_v;
	logic signed [VW-1:0]     dt_v;
	logic                     blep_lo;
	logic                     blep_hi;
	logic [PHASE_BITS:0]      hi_lim;
	logic [PHASE_BITS:0]      div_num;
	logic                     div_go;
	logic                     div_done;
	logic [FB-1:0]            div_q;
	logic                     mul_go;
	logic signed [AW-1:0]     mul_a;
	logic signed [BW-1:0]     mul_b;
	logic                     mul_done;
	logic signed [PW-1:0]     mul_p;
	logic [33:0]              p_hi;
	logic signed [VW-1:0]     contrib;
	logic                     blep_sub;
	logic [3:0]               after_blep;
	logic                     after_sec;
	logic signed [VW-1:0]     tri_sum;
	logic signed [VW-1:0]     tri_sat;
	logic signed [VW-1:0]     rnd;
	logic signed [OUT_BITS-1:0] rnd_sat;
	logic                     out_free;

	// Handshakes
	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// Clamp the increment to one half
	assign dt_in = (phase_step > PH_HALF) ? PH_HALF : phase_step;

	// Phase in the internal Q30 scale
	assign t_v  = VW'(t_q >> SHR) <<< SHL;
	assign dt_v = VW'(dt_q >> SHR) <<< SHL;

	// Sine table address from the read phase
	assign quad = t_q[PHASE_BITS-1 -: 2];
	assign addr = t_q[PHASE_BITS-3 -: SINE_ADDR_BITS];
	assign kk   = quad[0] ? ((SINE_ADDR_BITS + 1)'(1) << SINE_ADDR_BITS) - {1'b0, addr}
	                      : {1'b0, addr};
	assign xval = 32'(kk) << (FB - SINE_ADDR_BITS);

	// Edge-correction window tests
	assign hi_lim  = PH_ONE - {1'b0, dt_q};
	assign blep_lo = {1'b0, bt_q} < {1'b0, dt_q};
	assign blep_hi = {1'b0, bt_q} > hi_lim;
	assign div_num = blep_lo ? {1'b0, bt_q} : PH_ONE - {1'b0, bt_q};
	assign div_go  = (state_q == ST_BLEP) && (dt_q != '0) && (blep_lo || blep_hi);

	// Product scaled back from Q60 (non-negative uses)
	assign p_hi = mul_p[FB+33:FB];

	// Correction sign: saw subtracts, square adds its first and subtracts its second
	assign blep_sub = (wave_q == pbo_pkg::WAVE_SAW) || bidx_q;
	assign contrib  = (bneg_q ^ blep_sub) ? -VW'(p_hi) : VW'(p_hi);

	// Where to go once a correction is folded in
	always_comb begin
		after_sec  = 1'b0;
		after_blep = ST_ROUND;
		if (wave_q != pbo_pkg::WAVE_SAW) begin
			if (!bidx_q) begin
				after_sec  = 1'b1;
				after_blep = ST_BLEP;
			end else if (wave_q == pbo_pkg::WAVE_TRIANGLE) begin
				after_blep = ST_TRI;
			end
		end
	end

	// Triangle integrator update with saturation
	assign tri_sum = VW'(tri_q) + VW'(mul_p >>> 28);
	assign tri_sat = (tri_sum > TMAX_V) ? TMAX_V : ((tri_sum < TMIN_V) ? TMIN_V : tri_sum);

	// Round half up to the output format and saturate
	assign rnd     = (v_q + RND_V) >>> RSH;
	assign rnd_sat = (rnd > OMAX_V) ? OUT_BITS'(OMAX_V) :
	                 ((rnd < OMIN_V) ? OUT_BITS'(OMIN_V) : OUT_BITS'(rnd));

	// Multiplier operand selection
	always_comb begin
		mul_go = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			ST_START: begin
				if (wave_q == pbo_pkg::WAVE_SINE) begin
					mul_go = 1'b1;
					mul_a  = AW'(xval);
					mul_b  = BW'(xval);
				end
			end
			ST_HORN: begin
				mul_go = 1'b1;
				mul_a  = AW'(x2_q);
				mul_b  = BW'(p_q);
			end
			ST_SINX: begin
				mul_go = 1'b1;
				mul_a  = AW'(xval);
				mul_b  = BW'(p_q);
			end
			ST_DIVW: begin
				if (div_done) begin
					mul_go = 1'b1;
					mul_a  = AW'(ONE_V - VW'(div_q));
					mul_b  = BW'(ONE_V - VW'(div_q));
				end
			end
			ST_TRI: begin
				mul_go = 1'b1;
				mul_a  = AW'(dt_v);
				mul_b  = BW'(v_q - VW'(tri_q));
			end
			default: begin
				mul_go = 1'b0;
			end
		endcase
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_q <= pbo_pkg::WAVE_SINE;
		end else if (cfg_wen) begin
			wave_q <= cfg_wdata;
		end
	end

	// Output valid: raise on a new sample, drop once it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_ROUND) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Sequencer and oscillator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			accum_q     <= '0;
			tri_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						accum_q <= accum_q + dt_in;
						state_q <= ST_START;
					end
				end
				ST_START: begin
					state_q <= (wave_q == pbo_pkg::WAVE_SINE) ? ST_SQW : ST_BLEP;
				end
				ST_SQW: begin
					if (mul_done) begin
						state_q <= ST_HORN;
					end
				end
				ST_HORN: begin
					state_q <= ST_HORNW;
				end
				ST_HORNW: begin
					if (mul_done) begin
						state_q <= (hcnt_q == 3'd4) ? ST_SINX : ST_HORN;
					end
				end
				ST_SINX: begin
					state_q <= ST_SINXW;
				end
				ST_SINXW: begin
					if (mul_done) begin
						state_q <= ST_ROUND;
					end
				end
				ST_BLEP: begin
					state_q <= div_go ? ST_DIVW : after_blep;
				end
				ST_DIVW: begin
					if (div_done) begin
						state_q <= ST_RRW;
					end
				end
				ST_RRW: begin
					if (mul_done) begin
						state_q <= after_blep;
					end
				end
				ST_TRI: begin
					state_q <= ST_TRIW;
				end
				ST_TRIW: begin
					if (mul_done) begin
						tri_q   <= 32'(tri_sat);
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					if (out_free) begin
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers of the datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					dt_q <= dt_in;
					t_q  <= accum_q + read_offset;
				end
			end
			ST_START: begin
				bt_q   <= t_q;
				bidx_q <= 1'b0;
				hcnt_q <= '0;
				p_q    <= pbo_pkg::SIN_C11;
				if (wave_q == pbo_pkg::WAVE_SAW) begin
					v_q <= (t_v <<< 1) - ONE_V;
				end else begin
					v_q <= t_q[PHASE_BITS-1] ? -ONE_V : ONE_V;
				end
			end
			ST_SQW: begin
				if (mul_done) begin
					x2_q <= p_hi[31:0];
				end
			end
			ST_HORNW: begin
				if (mul_done) begin
					p_q    <= pbo_pkg::horner_coef(hcnt_q) - p_hi[31:0];
					hcnt_q <= hcnt_q + 3'd1;
				end
			end
			ST_SINXW: begin
				if (mul_done) begin
					v_q <= quad[1] ? -VW'(p_hi) : VW'(p_hi);
				end
			end
			ST_BLEP: begin
				bneg_q <= blep_lo;
				if (!div_go && after_sec) begin
					bidx_q <= 1'b1;
					bt_q   <= t_q + PH_HALF;
				end
			end
			ST_RRW: begin
				if (mul_done) begin
					v_q <= v_q + contrib;
					if (after_sec) begin
						bidx_q <= 1'b1;
						bt_q   <= t_q + PH_HALF;
					end
				end
			end
			ST_TRIW: begin
				if (mul_done) begin
					v_q <= tri_sat;
				end
			end
			ST_ROUND: begin
				if (out_free) begin
					sample_q <= rnd_sat;
				end
			end
			default: begin
				v_q <= v_q;
			end
		endcase
	end

	pbo_div #(
		.PHASE_BITS (PHASE_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.num    (div_num),
		.den    ({1'b0, dt_q}),
		.done   (div_done),
		.quot   (div_q)
	);

	pbo_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mul_go),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_p)
	);

	assign out_valid = out_valid_q;
	assign sample    = sample_q;

endmodule

// ----- tb/polyblep_oscillator_core_test.sv -----
// Self-checking testbench for polyblep_oscillator_core. It drives a directed
// table of items and then random items, and checks every sample.
// Depends on pbo_pkg and the core RTL only.
`timescale 1ns / 100ps

module polyblep_oscillator_core_test;

	localparam int    RANDOM_ITEMS = 734;
	localparam int    CALM_ITEMS   = 80;
	localparam int    CYCLE_LIMIT  = 400000;
	localparam longint ONE_Q30     = 64'sd1 << 30;
	localparam bit [63:0] WRAP     = 64'd1 << 32;
	localparam bit [63:0] HALF     = 64'd1 << 31;

	logic               clk;
	logic               arst_n;
	logic               cfg_wen;
	logic [1:0]         cfg_wdata;
	logic               in_valid;
	logic               in_stall;
	logic [31:0]        phase_step;
	logic [31:0]        read_offset;
	logic               out_valid;
	logic               out_stall;
	logic signed [15:0] sample;

	// Shadow state of the oscillator
	logic [31:0]        shadow_phase;
	logic signed [31:0] shadow_tri;
	logic [1:0]         shadow_wave;

	logic signed [15:0] pending_samples[$];
	int                 mismatches;
	int                 samples_seen;
	int                 cycles;
	bit                 calm;
	int                 stall_left;

	typedef struct {
		logic [1:0]         wave;
		logic [31:0]        step;
		logic [31:0]        offset;
		bit                 typed;
		logic signed [15:0] want;
	} tick_row_t;

	tick_row_t ticks[20] = '{
		'{pbo_pkg::WAVE_SINE,     32'h0000_0000, 32'h0000_0000, 1'b1, 16'sd0},
		'{pbo_pkg::WAVE_SINE,     32'h0000_0000, 32'h4000_0000, 1'b1, 16'sd32767},
		'{pbo_pkg::WAVE_SINE,     32'h0000_0000, 32'hC000_0000, 1'b1, 16'sh8000},
		'{pbo_pkg::WAVE_SINE,     32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 16'sd0},
		'{pbo_pkg::WAVE_SINE,     32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 16'sd0},
		'{pbo_pkg::WAVE_SAW,      32'h0000_0000, 32'h0000_0000, 1'b0, 16'sd0},
		'{pbo_pkg::WAVE_SAW,      32'h0100_0000, 32'h0000_0000, 1'b0, 16'sd0},
		'{pbo_pkg::WAVE_SAW,      32'h0100_0000, 32'hFFFF_FFFF, 1'b0, 16'sd0},
		'{pbo_pkg::WAVE_SAW,      32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 16'sd0},
		'{pbo_pkg::WAVE_SAW,      32'h0000_0001, 32'h0000_0000, 1'b0, 16'sd0},
		'{pbo_pkg::WAVE_SQUARE,   32'h0000_0000, 32'h4000_0000, 1'b0, 16'sd0},
		'{pbo_pkg::WAVE_SQUARE,   32'h0200_0000, 32'h7F00_0000, 1'b0, 16'sd0},
		'{pbo_pkg::WAVE_SQUARE,   32'h8000_0001, 32'h0000_0000, 1'b0, 16'sd0},
		'{pbo_pkg::WAVE_SQUARE,   32'h1000_0000, 32'h8000_0000, 1'b0, 16'sd0},
		'{pbo_pkg::WAVE_TRIANGLE, 32'h8000_0000, 32'h0000_0000, 1'b0, 16'sd0},
		'{pbo_pkg::WAVE_TRIANGLE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 16'sd0},
		'{pbo_pkg::WAVE_TRIANGLE, 32'h8000_0000, 32'h4000_0000, 1'b0, 16'sd0},
		'{pbo_pkg::WAVE_TRIANGLE, 32'h0000_0000, 32'h0000_0000, 1'b0, 16'sd0},
		'{pbo_pkg::WAVE_TRIANGLE, 32'h0010_0000, 32'h1234_5678, 1'b0, 16'sd0},
		'{pbo_pkg::WAVE_SINE,     32'h7FFF_FFFF, 32'h5555_5555, 1'b0, 16'sd0}
	};

	polyblep_oscillator_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.phase_step (phase_step),
		.read_offset(read_offset),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample     (sample)
	);

	// 10 ns clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// floor(num * 2^30 / den), num below den
	function automatic longint step_ratio(input bit [63:0] num, input bit [63:0] den);
		bit [63:0] rem;
		bit [63:0] q;
		rem = num;
		q   = 0;
		for (int i = 0; i < 30; i++) begin
			rem = rem << 1;
			q   = q << 1;
			if (rem >= den) begin
				rem  = rem - den;
				q[0] = 1'b1;
			end
		end
		return longint'(q);
	endfunction

	// Edge correction near a discontinuity
	function automatic longint edge_fix(input bit [63:0] t, input bit [63:0] dt);
		longint r;
		if (dt == 0)
			return 0;
		if (t < dt) begin
			r = ONE_Q30 - step_ratio(t, dt);
			return -((r * r) >>> 30);
		end
		if (t > WRAP - dt) begin
			r = ONE_Q30 - step_ratio(WRAP - t, dt);
			return (r * r) >>> 30;
		end
		return 0;
	endfunction

	function automatic longint quarter_sine(input bit [63:0] k);
		bit [63:0] x;
		bit [63:0] x2;
		bit [63:0] p;
		x  = k << 20;
		x2 = (x * x) >> 30;
		p  = 64'(pbo_pkg::SIN_C11);
		p  = 64'(pbo_pkg::SIN_C9) - ((x2 * p) >> 30);
		p  = 64'(pbo_pkg::SIN_C7) - ((x2 * p) >> 30);
		p  = 64'(pbo_pkg::SIN_C5) - ((x2 * p) >> 30);
		p  = 64'(pbo_pkg::SIN_C3) - ((x2 * p) >> 30);
		p  = 64'(pbo_pkg::SIN_C1) - ((x2 * p) >> 30);
		return longint'((x * p) >> 30);
	endfunction

	function automatic longint sine_at(input bit [31:0] t);
		bit [63:0] a;
		longint    v;
		a = 64'(t[29:20]);
		v = quarter_sine(t[30] ? 64'd1024 - a : a);
		return t[31] ? -v : v;
	endfunction

	function automatic longint square_at(input bit [31:0] t, input bit [63:0] dt);
		longint    v;
		bit [31:0] t2;
		t2 = t + 32'h8000_0000;
		v  = t[31] ? -ONE_Q30 : ONE_Q30;
		v  = v + edge_fix(64'(t), dt) - edge_fix(64'(t2), dt);
		return v;
	endfunction

	// Work out the sample for one accepted item and advance the shadow state
	function automatic logic signed [15:0] next_sample(input logic [31:0] step,
		input logic [31:0] offset);
		bit [63:0] dt;
		bit [31:0] t;
		longint    v;
		longint    tri_v;
		dt = (64'(step) > HALF) ? HALF : 64'(step);
		t  = shadow_phase + offset;
		case (shadow_wave)
			pbo_pkg::WAVE_SINE:   v = sine_at(t);
			pbo_pkg::WAVE_SAW:    v = 2 * longint'(t >> 2) - ONE_Q30 - edge_fix(64'(t), dt);
			pbo_pkg::WAVE_SQUARE: v = square_at(t, dt);
			default: begin
				tri_v = longint'(shadow_tri);
				tri_v = tri_v + ((longint'(dt >> 2) * (square_at(t, dt) - tri_v)) >>> 28);
				if (tri_v > 64'sd2147483647)
					tri_v = 64'sd2147483647;
				if (tri_v < -64'sd2147483648)
					tri_v = -64'sd2147483648;
				shadow_tri = tri_v[31:0];
				v = tri_v;
			end
		endcase
		shadow_phase = shadow_phase + dt[31:0];
		v = (v + (64'sd1 << 14)) >>> 15;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[15:0];
	endfunction

	// Offer one item, wait for it to be taken, then record its sample
	task automatic offer_tick(input logic [31:0] step, input logic [31:0] offset,
		input bit typed, input logic signed [15:0] want);
		logic signed [15:0] predicted;
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		phase_step  <= step;
		read_offset <= offset;
		do
			@(posedge clk);
		while (in_stall);
		predicted = next_sample(step, offset);
		pending_samples.push_back(typed ? want : predicted);
	endtask

	// Drain, settle, then write the waveform register
	task automatic set_wave(input logic [1:0] wave);
		in_valid <= 1'b0;
		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= wave;
		@(posedge clk);
		cfg_wen     <= 1'b0;
		shadow_wave  = wave;
	endtask

	function automatic logic [31:0] pick_step();
		case ($urandom_range(0, 9))
			0:       return 32'h0;
			1:       return $urandom | 32'h8000_0000;
			2:       return $urandom;
			3:       return 32'h8000_0000;
			default: return $urandom_range(1, 32'h0200_0000);
		endcase
	endfunction

	// Check samples and drive output stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				samples_seen++;
				if (pending_samples.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected sample %0d", sample);
				end else begin
					if (sample !== pending_samples[0]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("sample mismatch: expected %0d, got %0d",
								pending_samples[0], sample);
					end
					void'(pending_samples.pop_front());
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_stall  <= 1'b1;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				stall_left <= $urandom_range(0, 2);
				out_stall  <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Stop a run that hangs
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("polyblep_oscillator_core_test: FAIL");
			$finish;
		end
	end

	initial begin
		calm         = 1'b0;
		shadow_phase = '0;
		shadow_tri   = '0;
		shadow_wave  = pbo_pkg::WAVE_SINE;
		arst_n       = 1'b0;
		cfg_wen      = 1'b0;
		cfg_wdata    = pbo_pkg::WAVE_SINE;
		in_valid     = 1'b0;
		phase_step   = '0;
		read_offset  = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (ticks[i]) begin
			if (i == 0 || ticks[i].wave != shadow_wave)
				set_wave(ticks[i].wave);
			offer_tick(ticks[i].step, ticks[i].offset, ticks[i].typed, ticks[i].want);
		end

		// Random items in runs of one waveform
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 60 == 0)
				set_wave(2'($urandom_range(0, 3)));
			if (n == 330) begin
				in_valid <= 1'b0;
				while (pending_samples.size() != 0)
					@(posedge clk);
			end
			calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
			offer_tick(pick_step(), ($urandom_range(0, 1) == 0) ? 32'h0 : $urandom,
				1'b0, 16'sd0);
		end
		in_valid <= 1'b0;

		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		$display("ran %0d directed and %0d random items over all four waveforms,",
			$size(ticks), RANDOM_ITEMS);
		$display("with stalls on both sides; %0d samples checked, %0d mismatches",
			samples_seen, mismatches);
		if (mismatches == 0 && pending_samples.size() == 0)
			$display("polyblep_oscillator_core_test: PASS");
		else
			$display("polyblep_oscillator_core_test: FAIL");
		$finish;
	end

endmodule
